// ===== design/cpl_pkg.sv =====
// Package for the chassis power limiter: widths, thresholds, reset values and shared types.
// Has no dependencies. It is used by cpl_lane, cpl_seq and chassis_power_limiter.
package cpl_pkg;

   localparam int WHEELS  = 4;
   localparam int SPEED_W = 16;
   localparam int POWER_W = 16;
   localparam int DENOM_W = POWER_W + 1;
   localparam int TICK_W  = 8;
   localparam int STEP_W  = $clog2(SPEED_W);
   localparam int CSR_DATA_W = 16;

   // Excess thresholds and divisor offsets, in 1/16 W units (10/20/30 W and 35/60/80 W).
   localparam logic [POWER_W-1:0] EXCESS_STEP1 = 16'd160;
   localparam logic [POWER_W-1:0] EXCESS_STEP2 = 16'd320;
   localparam logic [POWER_W-1:0] EXCESS_STEP3 = 16'd480;
   localparam logic [DENOM_W-1:0] OFFSET1 = 17'd560;
   localparam logic [DENOM_W-1:0] OFFSET2 = 17'd960;
   localparam logic [DENOM_W-1:0] OFFSET3 = 17'd1280;

   localparam logic [POWER_W-1:0] POWER_LIMIT_RESET = 16'd1280;
   localparam logic [TICK_W-1:0]  CUT_AFTER_RESET   = 8'd200;
   localparam logic [TICK_W-1:0]  TICK_MAX          = 8'd255;

   typedef enum logic [0:0] {
      CSR_POWER_LIMIT     = 1'b0,
      CSR_CUT_AFTER_TICKS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_MULT,
      SEQ_DIV,
      SEQ_FIN
   } seq_state_type;

   typedef struct packed {
      logic load;
      logic mult_step;
      logic div_step;
   } lane_ctrl_type;

endpackage

// ===== design/chassis_power_limiter.sv =====
// Chassis power limiter: one request transaction per control tick carries the measured power and
// four wheel speed targets, and one response transaction returns the limited speeds and flags.
// When the power is at or above the limit with an excess under 30 W, every speed is scaled by
// limit / (power + offset), truncated toward zero. The four wheels have lanes of their own, each
// a bit-serial multiplier followed by a bit-serial restoring divider, one bit per cycle. A scaled
// transaction therefore passes through acceptance, the multiply steps, the divide steps and a
// hand-off before the next request is accepted; a transaction that passes its speeds through
// unchanged goes from acceptance straight to hand-off, which waits until the output register is
// free. The response sits in an output register, so the next request is taken while an earlier
// response still waits on rsp_stall. Configuration is written through the csr_ port and must
// only be written while the block is idle. The over-limit tick counter saturates at 255;
// drive-cut is raised while it exceeds cut_after_ticks.
// Depends on cpl_pkg, cpl_lane and cpl_seq.
module chassis_power_limiter import cpl_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_write_enable,
   input  logic [0:0]                   csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [POWER_W-1:0]           req_measured_power,
   input  logic signed [SPEED_W-1:0]    req_speed_0,
   input  logic signed [SPEED_W-1:0]    req_speed_1,
   input  logic signed [SPEED_W-1:0]    req_speed_2,
   input  logic signed [SPEED_W-1:0]    req_speed_3,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SPEED_W-1:0]    rsp_limited_speed_0,
   output logic signed [SPEED_W-1:0]    rsp_limited_speed_1,
   output logic signed [SPEED_W-1:0]    rsp_limited_speed_2,
   output logic signed [SPEED_W-1:0]    rsp_limited_speed_3,
   output logic                         rsp_over_limit,
   output logic                         rsp_cut_drive
);

   // Configuration registers.
   logic [POWER_W-1:0]  power_limit_ff, power_limit_in;
   logic [TICK_W-1:0]   cut_after_ff, cut_after_in;

   // Over-limit tick counter.
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [TICK_W-1:0]   tick_sat;

   // Transaction held while the lanes work.
   logic signed [SPEED_W-1:0] speed_ff [WHEELS];
   logic                      scale_ff;
   logic                      over_ff;
   logic                      cut_ff;
   logic [DENOM_W-1:0]        denom_ff;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff [WHEELS];
   logic                      rsp_over_ff;
   logic                      rsp_cut_ff;

   logic signed [SPEED_W-1:0] req_speed [WHEELS];
   logic signed [SPEED_W-1:0] lane_speed [WHEELS];

   logic                req_accept;
   logic                over_now;
   logic [POWER_W-1:0]  excess;
   logic [DENOM_W-1:0]  offset;
   logic                scale_now;
   logic [DENOM_W-1:0]  denom_now;

   lane_ctrl_type       lane_ctrl;
   logic                busy;
   logic                finish;
   logic                out_free;

   assign req_speed[0] = req_speed_0;
   assign req_speed[1] = req_speed_1;
   assign req_speed[2] = req_speed_2;
   assign req_speed[3] = req_speed_3;

   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Configuration writes. Both codes of the one-bit index name a register.
   always_comb begin
      power_limit_in = power_limit_ff;
      cut_after_in   = cut_after_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_POWER_LIMIT:     power_limit_in = csr_write_data[POWER_W-1:0];
            CSR_CUT_AFTER_TICKS: cut_after_in   = csr_write_data[TICK_W-1:0];
            default: begin
               power_limit_in = power_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_limit_ff <= POWER_LIMIT_RESET;
         cut_after_ff   <= CUT_AFTER_RESET;
      end else begin
         power_limit_ff <= power_limit_in;
         cut_after_ff   <= cut_after_in;
      end
   end

   // The decision is taken as the transaction is accepted. The excess only matters when the
   // power is at or above the limit, so the 16-bit difference cannot wrap where it is used.
   // An excess of 30 W or more leaves the offset at zero and the speeds unscaled.
   assign over_now = (req_measured_power >= power_limit_ff);
   assign excess   = req_measured_power - power_limit_ff;

   always_comb begin
      if (excess < EXCESS_STEP1) begin
         offset = OFFSET1;
      end else if (excess < EXCESS_STEP2) begin
         offset = OFFSET2;
      end else if (excess < EXCESS_STEP3) begin
         offset = OFFSET3;
      end else begin
         offset = '0;
      end
   end

   assign scale_now = over_now && (offset != '0);
   assign denom_now = {1'b0, req_measured_power} + offset;
   assign tick_sat  = (tick_ff == TICK_MAX) ? tick_ff : (tick_ff + 1'b1);

   always_comb begin
      tick_in = tick_ff;
      if (req_accept) begin
         tick_in = over_now ? tick_sat : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

   // Cut-off uses the threshold in force when the tick is taken; the user must change the
   // threshold only while idle (not enforced), so this matches a comparison at response time.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < WHEELS; i++) begin
            speed_ff[i] <= req_speed[i];
         end
         scale_ff <= scale_now;
         over_ff  <= over_now;
         cut_ff   <= over_now && (tick_sat > cut_after_ff);
         denom_ff <= denom_now;
      end
   end

   cpl_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .scale    (scale_now),
      .out_free (out_free),
      .ctrl     (lane_ctrl),
      .busy     (busy),
      .finish   (finish)
   );

   // The divisor is taken from the held copy, as the request ports move on once accepted.
   for (genvar g = 0; g < WHEELS; g++) begin : g_lane
      cpl_lane u_lane (
         .clock        (clock),
         .ctrl         (lane_ctrl),
         .speed        (req_speed[g]),
         .power_limit  (power_limit_ff),
         .denom        (denom_ff),
         .scaled_speed (lane_speed[g])
      );
   end

   // Output register: loaded on hand-off, emptied when the response transaction is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         for (int i = 0; i < WHEELS; i++) begin
            rsp_speed_ff[i] <= scale_ff ? lane_speed[i] : speed_ff[i];
         end
         rsp_over_ff <= over_ff;
         rsp_cut_ff  <= cut_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_limited_speed_0 = rsp_speed_ff[0];
   assign rsp_limited_speed_1 = rsp_speed_ff[1];
   assign rsp_limited_speed_2 = rsp_speed_ff[2];
   assign rsp_limited_speed_3 = rsp_speed_ff[3];
   assign rsp_over_limit      = rsp_over_ff;
   assign rsp_cut_drive       = rsp_cut_ff;

   // Drive is only ever cut on a tick that is itself over the limit.
   a_cut_needs_over: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_cut_drive || rsp_over_limit))
      else $error("drive cut reported without over-limit");

   // A tick below the limit clears the counter.
   a_tick_clear: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !over_now) |=> (tick_ff == '0))
      else $error("tick counter not cleared below limit");

   // An over-limit tick advances an unsaturated counter by exactly one.
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && over_now && (tick_ff != TICK_MAX))
      |=> (tick_ff == TICK_W'($past(tick_ff) + 1'b1)))
      else $error("tick counter did not advance");

   // No new transaction is taken while the lanes are stepping.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (lane_ctrl.mult_step || lane_ctrl.div_step) |-> !req_accept)
      else $error("request accepted while lanes busy");

endmodule

// ===== design/cpl_lane.sv =====
// One wheel lane: bit-serial multiply of |speed| by the limit, then bit-serial restoring divide.
// Depends on cpl_pkg; stepped by the lane_ctrl_type struct from cpl_seq.
module cpl_lane import cpl_pkg::*; (
   input  logic                      clock,
   input  lane_ctrl_type             ctrl,
   input  logic signed [SPEED_W-1:0] speed,
   input  logic [POWER_W-1:0]        power_limit,
   input  logic [DENOM_W-1:0]        denom,
   output logic signed [SPEED_W-1:0] scaled_speed
);

   logic                 neg_ff, neg_in;
   logic [SPEED_W-1:0]   mag_ff, mag_in;
   logic [DENOM_W-1:0]   hi_ff, hi_in;
   logic [SPEED_W-1:0]   lo_ff, lo_in;

   logic [SPEED_W-1:0]   speed_u;
   logic [SPEED_W:0]     mult_sum;
   logic [DENOM_W:0]     trial;
   logic [DENOM_W:0]     diff;
   logic                 fits;

   assign speed_u  = speed;
   assign mult_sum = {1'b0, hi_ff[SPEED_W-1:0]} + (lo_ff[0] ? {1'b0, mag_ff} : '0);
   assign trial    = {hi_ff, lo_ff[SPEED_W-1]};
   assign diff     = trial - {1'b0, denom};
   // The remainder is always below the divisor, so a clear sign bit means the trial fits.
   assign fits     = !diff[DENOM_W];

   always_comb begin
      neg_in = neg_ff;
      mag_in = mag_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      if (ctrl.load) begin
         neg_in = speed_u[SPEED_W-1];
         mag_in = speed_u[SPEED_W-1] ? (~speed_u + 1'b1) : speed_u;
         hi_in  = '0;
         lo_in  = power_limit;
      end else if (ctrl.mult_step) begin
         hi_in = {1'b0, mult_sum[SPEED_W:1]};
         lo_in = {mult_sum[0], lo_ff[SPEED_W-1:1]};
      end else if (ctrl.div_step) begin
         hi_in = fits ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
         lo_in = {lo_ff[SPEED_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign scaled_speed = neg_ff ? (~lo_ff + 1'b1) : lo_ff;

endmodule

// ===== design/cpl_seq.sv =====
// Sequencer for the lanes: a multiply pass and a divide pass of one step per bit, then hand-off.
// Depends on cpl_pkg.
module cpl_seq import cpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          scale,
   input  logic          out_free,
   output lane_ctrl_type ctrl,
   output logic          busy,
   output logic          finish
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SPEED_W - 1);

   seq_state_type       state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      ctrl           = '0;
      finish         = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               step_in   = '0;
               state_in  = scale ? SEQ_MULT : SEQ_FIN;
            end
         end
         SEQ_MULT: begin
            ctrl.mult_step = 1'b1;
            step_in        = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = SEQ_DIV;
               step_in  = '0;
            end
         end
         SEQ_DIV: begin
            ctrl.div_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = SEQ_FIN;
               step_in  = '0;
            end
         end
         SEQ_FIN: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != SEQ_IDLE);

endmodule
